[design/pixel_color_effect_macros.svh]
// ----------------------------------------------------------------------------
// pixel_color_effect assertion macros
// Concurrent assertion wrappers for the pixel color effect block; they compile
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PIXEL_COLOR_EFFECT_MACROS_SVH
`define PIXEL_COLOR_EFFECT_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define PCE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked during reset as well
`define PCE_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PCE_ASSERT(lbl, prop, msg)
`define PCE_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[design/pce_pkg.sv]
// ----------------------------------------------------------------------------
// pce_pkg
// Types, register map and effect constants shared by the pixel color effect
// block.
// ----------------------------------------------------------------------------
package pce_pkg;

   localparam int CHAN_W     = 8;
   localparam int DELTA_W    = 9;
   localparam int MODE_W     = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CHAN_W-1:0] CHANNEL_MAX = 8'd255;

   // floor(x/3) for x <= 765 as (x * 683) >> 11
   localparam int MEAN_SUM_W  = 10;
   localparam int MEAN_PROD_W = 19;
   localparam logic [MEAN_PROD_W-1:0] MEAN_RECIP = 19'd683;
   localparam int MEAN_SHIFT  = 11;

   // sepia weights, unsigned Q16, rounded to nearest
   localparam int SEPIA_ACC_W = 25;
   localparam logic [15:0] SEPIA_Q16 [3][3] = '{
      '{16'd25756, 16'd50397, 16'd12386},
      '{16'd22872, 16'd44958, 16'd11010},
      '{16'd17826, 16'd34996, 16'd8585 }
   };

   typedef enum logic [MODE_W-1:0] {
      MODE_GRAY       = 3'd0,
      MODE_SEPIA      = 3'd1,
      MODE_RED_MASK   = 3'd2,
      MODE_INVERT     = 3'd3,
      MODE_BRIGHTNESS = 3'd4,
      MODE_WARM       = 3'd5,
      MODE_COOL       = 3'd6
   } effect_mode_type;

   // register index = paddr[2]
   localparam logic REG_EFFECT_MODE   = 1'b0;
   localparam logic REG_CHANNEL_DELTA = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic signed [DELTA_W-1:0] delta;
   } effect_cfg_type;

endpackage

[design/pce_ifs.sv]
// ----------------------------------------------------------------------------
// pce_req_if / pce_rsp_if
// Valid/ready pixel channels: input pixels and effect results.
// ----------------------------------------------------------------------------
interface pce_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic [7:0] alpha_in;

   modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface pce_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

[design/pce_effect_unit.sv]
// ----------------------------------------------------------------------------
// pce_effect_unit
// Single-pass color effect datapath: gray, sepia, red mask, invert and the
// saturating delta effects. Alpha passes through.
// ----------------------------------------------------------------------------
module pce_effect_unit (
   input  pce_pkg::pixel_type      pix_in,
   input  pce_pkg::effect_cfg_type cfg,
   output pce_pkg::pixel_type      pix_out
);
   import pce_pkg::*;

   function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] ch,
                                                 input logic signed [DELTA_W-1:0] d);
      logic signed [DELTA_W+1:0] v;
      v = $signed({3'b000, ch}) + $signed({{2{d[DELTA_W-1]}}, d});
      if (v[DELTA_W+1]) begin
         return '0;
      end else if (v[DELTA_W:CHAN_W] != '0) begin
         return CHANNEL_MAX;
      end
      return v[CHAN_W-1:0];
   endfunction

   function automatic logic [CHAN_W-1:0] sepia_row(input logic [1:0] row,
                                                   input logic [CHAN_W-1:0] r,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] b);
      logic [SEPIA_ACC_W-1:0] acc;
      acc = SEPIA_ACC_W'(SEPIA_Q16[row][0]) * SEPIA_ACC_W'(r)
          + SEPIA_ACC_W'(SEPIA_Q16[row][1]) * SEPIA_ACC_W'(g)
          + SEPIA_ACC_W'(SEPIA_Q16[row][2]) * SEPIA_ACC_W'(b);
      if (acc[SEPIA_ACC_W-1:16+CHAN_W] != '0) begin
         return CHANNEL_MAX;
      end
      return acc[16+CHAN_W-1:16];
   endfunction

   logic [MEAN_SUM_W-1:0]  sum;
   logic [MEAN_PROD_W-1:0] mean_prod;
   logic [CHAN_W-1:0]      mean;

   assign sum       = MEAN_SUM_W'(pix_in.red) + MEAN_SUM_W'(pix_in.green)
                    + MEAN_SUM_W'(pix_in.blue);
   assign mean_prod = MEAN_PROD_W'(sum) * MEAN_RECIP;
   assign mean      = CHAN_W'(mean_prod >> MEAN_SHIFT);

   always_comb begin
      pix_out = pix_in;
      unique case (cfg.mode)
         MODE_GRAY: begin
            pix_out.red   = mean;
            pix_out.green = mean;
            pix_out.blue  = mean;
         end
         MODE_SEPIA: begin
            pix_out.red   = sepia_row(2'd0, pix_in.red, pix_in.green, pix_in.blue);
            pix_out.green = sepia_row(2'd1, pix_in.red, pix_in.green, pix_in.blue);
            pix_out.blue  = sepia_row(2'd2, pix_in.red, pix_in.green, pix_in.blue);
         end
         MODE_RED_MASK: begin
            pix_out.red   = mean;
            pix_out.green = '0;
            pix_out.blue  = '0;
         end
         MODE_INVERT: begin
            pix_out.red   = CHANNEL_MAX - pix_in.red;
            pix_out.green = CHANNEL_MAX - pix_in.green;
            pix_out.blue  = CHANNEL_MAX - pix_in.blue;
         end
         MODE_BRIGHTNESS: begin
            pix_out.red   = sat_add(pix_in.red, cfg.delta);
            pix_out.green = sat_add(pix_in.green, cfg.delta);
            pix_out.blue  = sat_add(pix_in.blue, cfg.delta);
         end
         MODE_WARM: begin
            pix_out.red   = sat_add(pix_in.red, cfg.delta);
            pix_out.green = sat_add(pix_in.green, cfg.delta);
         end
         MODE_COOL: begin
            pix_out.blue  = sat_add(pix_in.blue, cfg.delta);
         end
         default: begin
            // unused mode code: pixel passes unchanged
            pix_out = pix_in;
         end
      endcase
   end

endmodule

[design/pixel_color_effect.sv]
// ----------------------------------------------------------------------------
// pixel_color_effect
// RGBA per-pixel color effect with an APB-style register port.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one RGBA pixel per beat, rsp_bus returns one effected
//   pixel per beat, in order. The csr_ port holds effect_mode (byte address 0)
//   and channel_delta (byte address 4); write them only while the block is
//   empty. Alpha is passed through untouched.
// Throughput: one pixel per cycle while rsp_bus is not stalled. Each pixel passes
//   once through the effect datapath (the sepia multiply-add tree is the
//   longest path) between an input register and the result register.
// Stalls: when rsp_bus.ready is low the result holds; the input register
//   still takes one more pixel, then req_bus.ready drops until the result
//   beat is taken.
// Reset: synchronous, active high; empties both stages and sets effect_mode
//   to gray and channel_delta to zero.
// ----------------------------------------------------------------------------
`include "pixel_color_effect_macros.svh"

module pixel_color_effect (
   input  logic                             clock,
   input  logic                             reset,
   pce_req_if.sink                          req_bus,
   pce_rsp_if.source                        rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pce_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pce_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pce_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import pce_pkg::*;

   logic [MODE_W-1:0]      mode_reg_ff, mode_reg_in;
   logic [DELTA_W-1:0]     delta_ff, delta_in;
   logic                   csr_wr;
   effect_cfg_type         cfg;

   logic                   s0_valid_ff, s0_valid_in;
   pixel_type              s0_pix_ff, s0_pix_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pixel_type              rsp_pix_ff, rsp_pix_in;
   pixel_type              fx_pix;
   logic                   rsp_free, s0_adv, req_acc;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_reg_in = mode_reg_ff;
      delta_in    = delta_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_EFFECT_MODE) begin
            mode_reg_in = csr_pwdata[MODE_W-1:0];
         end else begin
            delta_in = csr_pwdata[DELTA_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_CHANNEL_DELTA) begin
         csr_prdata = CSR_DATA_W'(delta_ff);
      end else begin
         csr_prdata = CSR_DATA_W'(mode_reg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_reg_ff <= '0;
         delta_ff    <= '0;
      end else begin
         mode_reg_ff <= mode_reg_in;
         delta_ff    <= delta_in;
      end
   end

   assign cfg.mode  = mode_reg_ff;
   assign cfg.delta = $signed(delta_ff);

   // ---------------- pipeline control ----------------
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s0_adv        = s0_valid_ff && rsp_free;
   assign req_bus.ready = !s0_valid_ff || rsp_free;
   assign req_acc       = req_bus.valid && req_bus.ready;

   always_comb begin
      s0_pix_in   = s0_pix_ff;
      s0_valid_in = s0_valid_ff;
      if (req_acc) begin
         s0_valid_in     = 1'b1;
         s0_pix_in.red   = req_bus.red_in;
         s0_pix_in.green = req_bus.green_in;
         s0_pix_in.blue  = req_bus.blue_in;
         s0_pix_in.alpha = req_bus.alpha_in;
      end else if (s0_adv) begin
         s0_valid_in = 1'b0;
      end
   end

   pce_effect_unit u_effect (
      .pix_in  (s0_pix_ff),
      .cfg     (cfg),
      .pix_out (fx_pix)
   );

   always_comb begin
      rsp_pix_in   = rsp_pix_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s0_adv) begin
         rsp_valid_in = 1'b1;
         rsp_pix_in   = fx_pix;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_pix_ff  <= s0_pix_in;
      rsp_pix_ff <= rsp_pix_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.red_out   = rsp_pix_ff.red;
   assign rsp_bus.green_out = rsp_pix_ff.green;
   assign rsp_bus.blue_out  = rsp_pix_ff.blue;
   assign rsp_bus.alpha_out = rsp_pix_ff.alpha;

   // ---------------- assertions ----------------
   `PCE_ASSERT(a_s0_holds, (s0_valid_ff && !rsp_free) |=> (s0_valid_ff && $stable(s0_pix_ff)), "input stage lost or changed a stalled pixel")
   `PCE_ASSERT(a_acc_fills, req_acc |=> s0_valid_ff, "accepted beat not captured")
   `PCE_ASSERT(a_alpha_pass, s0_adv |=> (rsp_pix_ff.alpha == $past(s0_pix_ff.alpha)), "alpha changed in effect stage")
   `PCE_ASSERT_RST(a_reset_empty, reset |=> (!s0_valid_ff && !rsp_valid_ff), "pipeline not empty after reset")

endmodule

[test/pce_effect_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_effect_checker
// Passive checker for the pixel color effect block. It tracks register writes
// on the csr port, works out the effected pixel for every input beat and
// compares each result beat, channel by channel, against the oldest one.
// ----------------------------------------------------------------------------
module pce_effect_checker (
   input  logic                           clock,
   input  logic                           reset,
   pce_req_if                             req_bus,
   pce_rsp_if                             rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pce_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pce_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             mismatch_count,
   output int                             pending_count
);
   import pce_pkg::*;

   localparam int PIXEL_MAX = 255;

   // sepia weights, unsigned Q16
   localparam int unsigned SEPIA_RR = 25756;
   localparam int unsigned SEPIA_RG = 50397;
   localparam int unsigned SEPIA_RB = 12386;
   localparam int unsigned SEPIA_GR = 22872;
   localparam int unsigned SEPIA_GG = 44958;
   localparam int unsigned SEPIA_GB = 11010;
   localparam int unsigned SEPIA_BR = 17826;
   localparam int unsigned SEPIA_BG = 34996;
   localparam int unsigned SEPIA_BB = 8585;

   logic [MODE_W-1:0]         mode_q;
   logic signed [DELTA_W-1:0] delta_q;
   pixel_type                 expected_pixels[$];
   int                        errors = 0;

   function automatic logic [7:0] clamp_add(logic [7:0] chan, int offset);
      int sum;
      sum = int'(chan) + offset;
      if (sum < 0) return 8'd0;
      if (sum > PIXEL_MAX) return 8'(PIXEL_MAX);
      return 8'(sum);
   endfunction

   function automatic logic [7:0] sepia_weighted(int unsigned wr, int unsigned wg,
                                                  int unsigned wb, pixel_type px);
      int unsigned acc;
      acc = (wr * px.red + wg * px.green + wb * px.blue) >> 16;
      return (acc > PIXEL_MAX) ? 8'(PIXEL_MAX) : 8'(acc);
   endfunction

   function automatic pixel_type apply_effect(pixel_type px);
      pixel_type res;
      int        mean;
      int        offset;
      res    = px;
      mean   = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
      offset = delta_q;
      case (mode_q)
         MODE_GRAY: begin
            res.red   = 8'(mean);
            res.green = 8'(mean);
            res.blue  = 8'(mean);
         end
         MODE_SEPIA: begin
            res.red   = sepia_weighted(SEPIA_RR, SEPIA_RG, SEPIA_RB, px);
            res.green = sepia_weighted(SEPIA_GR, SEPIA_GG, SEPIA_GB, px);
            res.blue  = sepia_weighted(SEPIA_BR, SEPIA_BG, SEPIA_BB, px);
         end
         MODE_RED_MASK: begin
            res.red   = 8'(mean);
            res.green = 8'd0;
            res.blue  = 8'd0;
         end
         MODE_INVERT: begin
            res.red   = 8'(PIXEL_MAX) - px.red;
            res.green = 8'(PIXEL_MAX) - px.green;
            res.blue  = 8'(PIXEL_MAX) - px.blue;
         end
         MODE_BRIGHTNESS: begin
            res.red   = clamp_add(px.red, offset);
            res.green = clamp_add(px.green, offset);
            res.blue  = clamp_add(px.blue, offset);
         end
         MODE_WARM: begin
            res.red   = clamp_add(px.red, offset);
            res.green = clamp_add(px.green, offset);
         end
         MODE_COOL: begin
            res.blue  = clamp_add(px.blue, offset);
         end
         default: begin
            // unused mode code: pixel passes through
         end
      endcase
      return res;
   endfunction

   task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         mode_q  = MODE_GRAY;
         delta_q = '0;
         expected_pixels.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_CHANNEL_DELTA)
               delta_q = csr_pwdata[DELTA_W-1:0];
            else
               mode_q = csr_pwdata[MODE_W-1:0];
         end
         if (req_bus.valid && req_bus.ready)
            expected_pixels.push_back(apply_effect({req_bus.red_in, req_bus.green_in,
                                                    req_bus.blue_in, req_bus.alpha_in}));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("result beat with no pixel pending");
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               check_channel("red_out", want.red, rsp_bus.red_out);
               check_channel("green_out", want.green, rsp_bus.green_out);
               check_channel("blue_out", want.blue, rsp_bus.blue_out);
               check_channel("alpha_out", want.alpha, rsp_bus.alpha_out);
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_pixels.size();
   end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for pixel_color_effect: a short directed pass over every effect
// and the edge cases, then randomized pixel phases under changing register
// settings, with random gaps on the input and stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
   import pce_pkg::*;

   localparam logic [MODE_W-1:0]     MODE_UNUSED        = 3'd7;
   localparam logic [CSR_ADDR_W-1:0] ADDR_EFFECT_MODE   = {REG_EFFECT_MODE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_CHANNEL_DELTA = {REG_CHANNEL_DELTA, 2'b00};
   localparam int PHASES          = 16;
   localparam int ITEMS_PER_PHASE = 122;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RUN_LIMIT_NS    = 5_000_000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatch_count;
   int                    pending_count;
   bit                    req_gaps_on;
   bit                    rsp_stalls_on;
   int                    stall_left = 0;

   pce_req_if req_bus ();
   pce_rsp_if rsp_bus ();

   pixel_color_effect dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pce_effect_checker u_effect_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly back-to-back, sometimes a short gap, rarely a long hole
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      return {random_channel(), random_channel(), random_channel(), random_channel()};
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (rsp_stalls_on && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
      end
   end

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(logic [MODE_W-1:0] mode, logic [DELTA_W-1:0] delta);
      wait_drained();
      write_reg(ADDR_EFFECT_MODE, CSR_DATA_W'(mode));
      write_reg(ADDR_CHANNEL_DELTA, CSR_DATA_W'(delta));
   endtask

   task automatic send_pixel(pixel_type px);
      int gap;
      req_bus.valid    <= 1'b1;
      req_bus.red_in   <= px.red;
      req_bus.green_in <= px.green;
      req_bus.blue_in  <= px.blue;
      req_bus.alpha_in <= px.alpha;
      do @(posedge clock); while (!req_bus.ready);
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      logic [MODE_W-1:0]  mode;
      logic [DELTA_W-1:0] delta;
      reset            <= 1'b1;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.red_in   <= '0;
      req_bus.green_in <= '0;
      req_bus.blue_in  <= '0;
      req_bus.alpha_in <= '0;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // register defaults straight out of reset: gray, no offset
      send_pixel({8'd10, 8'd20, 8'd33, 8'h80});
      send_pixel({8'd255, 8'd255, 8'd255, 8'd255});

      // sepia saturates on white
      set_config(MODE_SEPIA, 9'd0);
      send_pixel({8'd255, 8'd255, 8'd255, 8'd0});
      send_pixel({8'd0, 8'd0, 8'd0, 8'd255});
      send_pixel({8'd100, 8'd50, 8'd20, 8'd7});

      set_config(MODE_RED_MASK, 9'd0);
      send_pixel({8'd255, 8'd254, 8'd253, 8'd1});

      set_config(MODE_INVERT, 9'd0);
      send_pixel({8'd0, 8'd255, 8'd170, 8'd85});

      set_config(MODE_BRIGHTNESS, 9'd255);
      send_pixel({8'd0, 8'd128, 8'd255, 8'd0});

      // 0x100 is the most negative offset
      set_config(MODE_BRIGHTNESS, 9'(-256));
      send_pixel({8'd255, 8'd128, 8'd0, 8'd255});

      set_config(MODE_BRIGHTNESS, 9'(-255));
      send_pixel({8'd255, 8'd254, 8'd1, 8'd3});

      set_config(MODE_WARM, 9'd1);
      send_pixel({8'd254, 8'd255, 8'd0, 8'd9});

      set_config(MODE_COOL, 9'(-1));
      send_pixel({8'd0, 8'd1, 8'd255, 8'd9});

      set_config(MODE_UNUSED, 9'd5);
      send_pixel({8'd12, 8'd34, 8'd56, 8'd78});

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin req_gaps_on = 1'b1; rsp_stalls_on = 1'b1; end
            1: begin req_gaps_on = 1'b1; rsp_stalls_on = 1'b0; end
            2: begin req_gaps_on = 1'b0; rsp_stalls_on = 1'b1; end
            default: begin req_gaps_on = 1'b0; rsp_stalls_on = 1'b0; end
         endcase
         mode = MODE_W'(phase % 8);
         case (phase)
            4:       delta = 9'(-256);
            5:       delta = 9'd255;
            6:       delta = 9'(-255);
            7:       delta = 9'd1;
            default: delta = (phase < 8) ? 9'd0 : 9'($urandom_range(0, 511));
         endcase
         set_config(mode, delta);
         repeat (ITEMS_PER_PHASE) send_pixel(random_pixel());
      end

      wait_drained();
      if (mismatch_count == 0 && pending_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
